// File: hdl/terast_pkg.sv
// Shared types and constants for the triangle edge-function rasterizer.
package terast_pkg;

    // Field widths
    localparam int COORD_W    = 10;
    localparam int DEPTH_W    = 32;
    localparam int WEIGHT_W   = 17;
    localparam int EDGE_W     = 22;
    localparam int DIFF_W     = 12;
    localparam int NUM_W      = 56;
    localparam int PROD_W     = 54;
    localparam int LIM_W      = 39;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // Defaults
    localparam int SCREEN_WIDTH_DEF  = 1024;
    localparam int SCREEN_HEIGHT_DEF = 1024;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE = 17'd65536;
    localparam logic [WEIGHT_W-1:0]   BAND_RESET = 17'd1311;
    localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = 32'sh7fffffff;

    // Raster modes
    localparam logic [MODE_W-1:0] MODE_FILL  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POINT = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_BAND   = 2'd1;

    // Input item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef logic signed [EDGE_W-1:0]  t_edge;
    typedef logic signed [DEPTH_W-1:0] t_depth;

    // One job from the front to the back
    typedef struct packed {
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic               last;
        logic               direct;  // result fully known, no arithmetic
        logic               dcov;    // coverage of a direct result
        logic [1:0]         pidx;    // vertex of a point result
        logic               line;    // edge band test applies
        t_edge              ea;
        t_edge              eb;
        t_edge              ec;
        t_edge              d;
        t_depth             z0;
        t_depth             z1;
        t_depth             z2;
    } t_job;

endpackage

// File: hdl/terast_fifo.sv
// Small job queue between the front and the back.
module terast_fifo #(
    parameter int DEPTH = terast_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  terast_pkg::t_job  i_data,
    output logic              o_full,
    input  logic              i_pop,
    output terast_pkg::t_job  o_data,
    output logic              o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    terast_pkg::t_job  r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop && !o_empty) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push && !o_full) - CNT_W'(i_pop && !o_empty);
        end
    end
endmodule

// File: hdl/terast_front.sv
// Front end: triangle setup, pixel scan with incremental edge values, job issue.
module terast_front #(
    parameter int SCREEN_WIDTH  = terast_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = terast_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_kind,
    input  logic [terast_pkg::COORD_W-1:0]         i_x0,
    input  logic [terast_pkg::COORD_W-1:0]         i_y0,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_z0,
    input  logic [terast_pkg::COORD_W-1:0]         i_x1,
    input  logic [terast_pkg::COORD_W-1:0]         i_y1,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_z1,
    input  logic [terast_pkg::COORD_W-1:0]         i_x2,
    input  logic [terast_pkg::COORD_W-1:0]         i_y2,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_z2,
    input  logic [terast_pkg::MODE_W-1:0]          i_mode,
    input  logic                                   i_q_full,
    output logic                                   o_push,
    output terast_pkg::t_job                       o_job
);
    localparam int CW = terast_pkg::COORD_W;
    localparam int DW = terast_pkg::DIFF_W;
    localparam int EW = terast_pkg::EDGE_W;
    localparam logic [12:0] XLIM = 13'(SCREEN_WIDTH - 1);
    localparam logic [12:0] YLIM = 13'(SCREEN_HEIGHT - 1);

    typedef enum logic [1:0] {F_RUN, F_SETUP_BOX, F_SETUP_EDGE} t_fstate;

    t_fstate                    r_state;
    logic [CW-1:0]              r_vx [3];
    logic [CW-1:0]              r_vy [3];
    terast_pkg::t_depth         r_z [3];
    logic [CW-1:0]              r_minx, r_miny, r_maxx, r_maxy;
    terast_pkg::t_edge          r_d;
    logic signed [DW-1:0]       r_ddx [3];   // edge change per column
    logic signed [DW-1:0]       r_ddy [3];   // edge change per row
    terast_pkg::t_edge          r_e [3];     // edge values at the scan pixel
    terast_pkg::t_edge          r_ecol [3];  // edge values at top of the column
    logic [CW-1:0]              r_sx, r_sy;
    logic [1:0]                 r_pidx;
    logic                       r_done;

    logic signed [DW-1:0]       w_dx [3];
    logic signed [DW-1:0]       w_dy [3];
    logic signed [2*DW-1:0]     w_dp0, w_dp1;
    terast_pkg::t_edge          w_d;
    logic signed [2*DW-1:0]     w_sp0 [3];
    logic signed [2*DW-1:0]     w_sp1 [3];
    logic [CW-1:0]              w_bminx, w_bminy, w_bmaxx, w_bmaxy;
    logic                       w_accept, w_step, w_empty, w_ywrap, w_xend;
    logic [1:0]                 w_k;

    function automatic logic [CW-1:0] f_clamp(input logic [CW-1:0] c, input logic [12:0] lim);
        logic [12:0] v;
        v = {3'b000, c};
        return (v > lim) ? lim[CW-1:0] : c;
    endfunction

    function automatic logic signed [DW-1:0] f_sub(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return $signed({2'b00, a}) - $signed({2'b00, b});
    endfunction

    assign w_accept = i_in_valid && o_in_ready;
    assign w_step   = w_accept && (i_kind == terast_pkg::KIND_STEP) && !r_done;
    assign o_in_ready = (r_state == F_RUN) && !i_q_full;

    // Edge deltas, determinant and bounding box from the stored vertices
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dx[i] = f_sub(r_vy[(i + 2) % 3], r_vy[(i + 1) % 3]);
            w_dy[i] = f_sub(r_vx[(i + 1) % 3], r_vx[(i + 2) % 3]);
            w_sp0[i] = f_sub(r_minx, r_vx[(i + 1) % 3]) * r_ddx[i];
            w_sp1[i] = f_sub(r_miny, r_vy[(i + 1) % 3]) * r_ddy[i];
        end
        w_dp0 = f_sub(r_vx[2], r_vx[0]) * w_dx[2];
        w_dp1 = f_sub(r_vy[2], r_vy[0]) * w_dy[2];
        w_d   = EW'(w_dp0 + w_dp1);
        w_bminx = r_vx[0];
        w_bminy = r_vy[0];
        w_bmaxx = r_vx[0];
        w_bmaxy = r_vy[0];
        for (int i = 1; i < 3; i++) begin
            if (r_vx[i] < w_bminx) w_bminx = r_vx[i];
            if (r_vy[i] < w_bminy) w_bminy = r_vy[i];
            if (r_vx[i] > w_bmaxx) w_bmaxx = r_vx[i];
            if (r_vy[i] > w_bmaxy) w_bmaxy = r_vy[i];
        end
    end

    // Scan position tests
    assign w_empty = (r_minx >= r_maxx) || (r_miny >= r_maxy);
    assign w_ywrap = ({1'b0, r_sy} + 1'b1) >= {1'b0, r_maxy};
    assign w_xend  = ({1'b0, r_sx} + 1'b1) >= {1'b0, r_maxx};
    assign w_k     = (r_pidx > 2'd2) ? 2'd2 : r_pidx;

    // Job build
    always_comb begin
        o_job      = '0;
        o_job.ea   = r_e[0];
        o_job.eb   = r_e[1];
        o_job.ec   = r_e[2];
        o_job.d    = r_d;
        o_job.z0   = r_z[0];
        o_job.z1   = r_z[1];
        o_job.z2   = r_z[2];
        o_job.line = (i_mode == terast_pkg::MODE_LINE);
        o_job.px   = r_sx;
        o_job.py   = r_sy;
        o_job.last = w_ywrap && w_xend;
        if (i_mode == terast_pkg::MODE_POINT) begin
            o_job.direct = 1'b1;
            o_job.dcov   = 1'b1;
            o_job.pidx   = w_k;
            o_job.px     = r_vx[w_k];
            o_job.py     = r_vy[w_k];
            o_job.z0     = r_z[w_k];
            o_job.last   = (w_k == 2'd2);
        end else if (w_empty) begin
            o_job.direct = 1'b1;
            o_job.px     = r_minx;
            o_job.py     = r_miny;
            o_job.last   = 1'b1;
        end
    end

    assign o_push = w_step;

    // Control and triangle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_RUN;
            r_done  <= 1'b1;
            r_pidx  <= '0;
        end else begin
            unique case (r_state)
                F_RUN: begin
                    if (w_accept && i_kind == terast_pkg::KIND_LOAD) begin
                        r_vx[0] <= f_clamp(i_x0, XLIM);
                        r_vy[0] <= f_clamp(i_y0, YLIM);
                        r_vx[1] <= f_clamp(i_x1, XLIM);
                        r_vy[1] <= f_clamp(i_y1, YLIM);
                        r_vx[2] <= f_clamp(i_x2, XLIM);
                        r_vy[2] <= f_clamp(i_y2, YLIM);
                        r_z[0]  <= i_z0;
                        r_z[1]  <= i_z1;
                        r_z[2]  <= i_z2;
                        r_pidx  <= '0;
                        r_done  <= 1'b0;
                        r_state <= F_SETUP_BOX;
                    end else if (w_step) begin
                        if (i_mode == terast_pkg::MODE_POINT) begin
                            if (w_k == 2'd2) r_done <= 1'b1;
                            else r_pidx <= w_k + 2'd1;
                        end else if (w_empty) begin
                            r_done <= 1'b1;
                        end else if (w_ywrap) begin
                            r_sy <= r_miny;
                            r_sx <= r_sx + 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                r_ecol[i] <= r_ecol[i] + EW'(r_ddx[i]);
                                r_e[i]    <= r_ecol[i] + EW'(r_ddx[i]);
                            end
                            if (w_xend) r_done <= 1'b1;
                        end else begin
                            r_sy <= r_sy + 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                r_e[i] <= r_e[i] + EW'(r_ddy[i]);
                            end
                        end
                    end
                end
                F_SETUP_BOX: begin
                    r_minx <= w_bminx;
                    r_miny <= w_bminy;
                    r_maxx <= w_bmaxx;
                    r_maxy <= w_bmaxy;
                    r_d    <= (w_d == '0) ? EW'(1) : w_d;
                    for (int i = 0; i < 3; i++) begin
                        r_ddx[i] <= w_dx[i];
                        r_ddy[i] <= w_dy[i];
                    end
                    r_state <= F_SETUP_EDGE;
                end
                F_SETUP_EDGE: begin
                    for (int i = 0; i < 3; i++) begin
                        r_e[i]    <= EW'(w_sp0[i] + w_sp1[i]);
                        r_ecol[i] <= EW'(w_sp0[i] + w_sp1[i]);
                    end
                    r_sx    <= r_minx;
                    r_sy    <= r_miny;
                    r_state <= F_RUN;
                end
                default: r_state <= F_RUN;
            endcase
        end
    end
endmodule

// File: hdl/terast_back.sv
// Back end: coverage, edge band test, depth sum and serial division into weights.
module terast_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_empty,
    output logic                                   o_pop,
    input  terast_pkg::t_job                       i_job,
    input  logic [terast_pkg::WEIGHT_W-1:0]        i_edge_band,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [terast_pkg::COORD_W-1:0]         o_pixel_x,
    output logic [terast_pkg::COORD_W-1:0]         o_pixel_y,
    output logic                                   o_covered,
    output logic [terast_pkg::WEIGHT_W-1:0]        o_weight_a,
    output logic [terast_pkg::WEIGHT_W-1:0]        o_weight_b,
    output logic [terast_pkg::WEIGHT_W-1:0]        o_weight_c,
    output logic signed [terast_pkg::DEPTH_W-1:0]  o_frag_depth,
    output logic                                   o_last
);
    localparam int EW = terast_pkg::EDGE_W;
    localparam int WW = terast_pkg::WEIGHT_W;
    localparam int NW = terast_pkg::NUM_W;
    localparam int PW = terast_pkg::PROD_W;
    localparam int LW = terast_pkg::LIM_W;
    localparam int DW = terast_pkg::DEPTH_W;
    localparam int RW = EW + 1;       // remainder
    localparam int QW = DW - 1;       // quotient bits for depth

    typedef enum logic [2:0] {B_IDLE, B_LIM, B_TEST, B_MAC, B_DSET, B_DIV, B_OUT} t_bstate;

    t_bstate               r_state;
    terast_pkg::t_job      r_job;
    logic                  r_cov;
    logic [LW-1:0]         r_lim;
    logic signed [PW-1:0]  r_prod;
    logic signed [NW-1:0]  r_acc;
    logic [4:0]            r_cnt;
    logic [1:0]            r_k;
    logic [RW-1:0]         r_rem;
    logic [QW-1:0]         r_low;
    logic [QW-1:0]         r_q;
    logic [EW-1:0]         r_dv;
    logic [WW-1:0]         r_w [3];
    logic signed [DW-1:0]  r_dep;

    terast_pkg::t_edge     w_e [3];
    logic [EW-1:0]         w_eabs [3];
    logic [EW-1:0]         w_dabs;
    logic [2:0]            w_unit;
    logic [2:0]            w_near;
    terast_pkg::t_edge     w_emac;
    terast_pkg::t_depth    w_zmac;
    logic signed [PW-1:0]  w_prod;
    logic [EW-1:0]         w_esel;
    logic [NW-1:0]         w_nabs;
    logic                  w_neg, w_ovf, w_ge;
    logic [RW:0]           w_t;
    logic [RW-1:0]         w_rem;
    logic [QW-1:0]         w_q;
    logic [DW-1:0]         w_q32;
    logic                  w_out_load;

    assign o_pop = (r_state == B_IDLE) && !i_q_empty;

    // Output register takes a new result when empty or being drained
    assign w_out_load = (r_state == B_OUT) && (!o_out_valid || i_out_ready);

    // Edge magnitudes, coverage and band test
    always_comb begin
        w_e[0] = r_job.ea;
        w_e[1] = r_job.eb;
        w_e[2] = r_job.ec;
        w_dabs = r_job.d[EW-1] ? EW'(-r_job.d) : EW'(r_job.d);
        for (int i = 0; i < 3; i++) begin
            w_eabs[i] = w_e[i][EW-1] ? EW'(-w_e[i]) : EW'(w_e[i]);
            if (!r_job.d[EW-1])
                w_unit[i] = !w_e[i][EW-1] && (w_e[i] <= r_job.d);
            else
                w_unit[i] = (w_e[i] <= 0) && (w_e[i] >= r_job.d);
            w_near[i] = {1'b0, w_eabs[i], 16'h0000} < r_lim;
        end
    end

    // Depth sum operand and divider dividend select
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin w_emac = r_job.ea; w_zmac = r_job.z0; end
            2'd1:    begin w_emac = r_job.eb; w_zmac = r_job.z1; end
            default: begin w_emac = r_job.ec; w_zmac = r_job.z2; end
        endcase
        case (r_k)
            2'd0:    w_esel = w_eabs[0];
            2'd1:    w_esel = w_eabs[1];
            default: w_esel = w_eabs[2];
        endcase
    end
    assign w_prod = w_emac * w_zmac;

    // Division operands and one restoring step
    assign w_nabs = r_acc[NW-1] ? NW'(-r_acc) : NW'(r_acc);
    assign w_neg  = r_acc[NW-1] ^ r_job.d[EW-1];
    assign w_ovf  = w_nabs[NW-1:QW] >= {{(NW-QW-EW){1'b0}}, r_dv};
    assign w_t    = {r_rem, r_low[QW-1]};
    assign w_ge   = w_t >= {2'b00, r_dv};
    assign w_rem  = w_ge ? RW'(w_t - {2'b00, r_dv}) : RW'(w_t);
    assign w_q    = {r_q[QW-2:0], w_ge};
    assign w_q32  = {1'b0, w_q};

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            o_out_valid <= w_out_load || (o_out_valid && !i_out_ready);
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_job <= i_job;
                        if (i_job.direct) begin
                            r_cov <= i_job.dcov;
                            for (int i = 0; i < 3; i++) begin
                                r_w[i] <= (i_job.dcov && i_job.pidx == 2'(i))
                                          ? terast_pkg::WEIGHT_ONE : '0;
                            end
                            r_dep   <= i_job.dcov ? i_job.z0 : '0;
                            r_state <= B_OUT;
                        end else begin
                            r_state <= B_LIM;
                        end
                    end
                end
                B_LIM: begin
                    r_dv    <= w_dabs;
                    r_lim   <= i_edge_band * w_dabs;
                    r_cov   <= &w_unit;
                    r_state <= B_TEST;
                end
                B_TEST: begin
                    if (r_cov && (!r_job.line || (|w_near))) begin
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_state <= B_MAC;
                    end else begin
                        r_cov   <= 1'b0;
                        for (int i = 0; i < 3; i++) r_w[i] <= '0;
                        r_dep   <= '0;
                        r_state <= B_OUT;
                    end
                end
                B_MAC: begin
                    r_prod <= w_prod;
                    if (r_cnt != '0) r_acc <= r_acc + NW'(r_prod);
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd3) begin
                        r_k     <= '0;
                        r_state <= B_DSET;
                    end
                end
                B_DSET: begin
                    r_q <= '0;
                    if (r_k != 2'd3) begin
                        r_rem   <= RW'(w_esel >> 1);
                        r_low   <= {w_esel[0], {(QW-1){1'b0}}};
                        r_cnt   <= 5'(WW);
                        r_state <= B_DIV;
                    end else if (w_ovf) begin
                        r_dep   <= w_neg ? -terast_pkg::DEPTH_MAX : terast_pkg::DEPTH_MAX;
                        r_state <= B_OUT;
                    end else begin
                        r_rem   <= w_nabs[QW+RW-1:QW];
                        r_low   <= w_nabs[QW-1:0];
                        r_cnt   <= 5'(QW);
                        r_state <= B_DIV;
                    end
                end
                B_DIV: begin
                    r_rem <= w_rem;
                    r_low <= {r_low[QW-2:0], 1'b0};
                    r_q   <= w_q;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == 5'd1) begin
                        if (r_k == 2'd3) begin
                            r_dep   <= w_neg ? $signed(-w_q32) : $signed(w_q32);
                            r_state <= B_OUT;
                        end else begin
                            r_w[r_k] <= w_q[WW-1:0];
                            r_k      <= r_k + 1'b1;
                            r_state  <= B_DSET;
                        end
                    end
                end
                B_OUT: begin
                    if (w_out_load) begin
                        o_pixel_x    <= r_job.px;
                        o_pixel_y    <= r_job.py;
                        o_covered    <= r_cov;
                        o_weight_a   <= r_w[0];
                        o_weight_b   <= r_w[1];
                        o_weight_c   <= r_w[2];
                        o_frag_depth <= r_dep;
                        o_last       <= r_job.last;
                        r_state      <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/triangle_edge_function_rasterizer_top.sv
// Top level of the triangle edge-function rasterizer: config registers, front, queue, back.
// A load passes through the box and edge setup states; a step is taken while the job queue
// has room. Vertex points and empty boxes need no arithmetic and uncovered pixels end after
// the band test; covered pixels use the bit-serial divider in the back end (17 steps per
// weight, 31 for depth unless it saturates). The back end holds one job at a time and pops
// the next only once the last result is in the output register. Reset is synchronous, active
// low: scan finished, queue and output empty, fill mode, band 1311.
module triangle_edge_function_rasterizer_top #(
    parameter int SCREEN_WIDTH  = terast_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = terast_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [terast_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [terast_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_kind,
    input  logic [terast_pkg::COORD_W-1:0]         i_x0,
    input  logic [terast_pkg::COORD_W-1:0]         i_y0,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_z0,
    input  logic [terast_pkg::COORD_W-1:0]         i_x1,
    input  logic [terast_pkg::COORD_W-1:0]         i_y1,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_z1,
    input  logic [terast_pkg::COORD_W-1:0]         i_x2,
    input  logic [terast_pkg::COORD_W-1:0]         i_y2,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_z2,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [terast_pkg::COORD_W-1:0]         o_pixel_x,
    output logic [terast_pkg::COORD_W-1:0]         o_pixel_y,
    output logic                                   o_covered,
    output logic [terast_pkg::WEIGHT_W-1:0]        o_weight_a,
    output logic [terast_pkg::WEIGHT_W-1:0]        o_weight_b,
    output logic [terast_pkg::WEIGHT_W-1:0]        o_weight_c,
    output logic signed [terast_pkg::DEPTH_W-1:0]  o_frag_depth,
    output logic                                   o_last
);
    logic [terast_pkg::MODE_W-1:0]   r_mode;
    logic [terast_pkg::WEIGHT_W-1:0] r_band;
    logic                            w_push, w_pop, w_full, w_empty;
    terast_pkg::t_job                w_job_in, w_job_out;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= terast_pkg::MODE_FILL;
            r_band <= terast_pkg::BAND_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                terast_pkg::CFG_RASTER_MODE: r_mode <= i_cfg_data[terast_pkg::MODE_W-1:0];
                terast_pkg::CFG_EDGE_BAND:   r_band <= i_cfg_data;
                default: ;
            endcase
        end
    end

    terast_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_x0       (i_x0),
        .i_y0       (i_y0),
        .i_z0       (i_z0),
        .i_x1       (i_x1),
        .i_y1       (i_y1),
        .i_z1       (i_z1),
        .i_x2       (i_x2),
        .i_y2       (i_y2),
        .i_z2       (i_z2),
        .i_mode     (r_mode),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    terast_fifo #(
        .DEPTH (terast_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    terast_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_empty),
        .o_pop        (w_pop),
        .i_job        (w_job_out),
        .i_edge_band  (r_band),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_covered    (o_covered),
        .o_weight_a   (o_weight_a),
        .o_weight_b   (o_weight_b),
        .o_weight_c   (o_weight_c),
        .o_frag_depth (o_frag_depth),
        .o_last       (o_last)
    );
endmodule

// File: hdl/terast_checker.sv
// Port-level checks of the rasterizer output channel, bound to the top level.
module terast_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic                                   o_covered,
    input logic [terast_pkg::WEIGHT_W-1:0]        o_weight_a,
    input logic [terast_pkg::WEIGHT_W-1:0]        o_weight_b,
    input logic [terast_pkg::WEIGHT_W-1:0]        o_weight_c,
    input logic signed [terast_pkg::DEPTH_W-1:0]  o_frag_depth
);
    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // Uncovered results carry zero weights and depth
    a_uncov_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_covered |-> (o_weight_a == '0) && (o_weight_b == '0)
            && (o_weight_c == '0) && (o_frag_depth == '0))
        else $error("uncovered result with nonzero payload");

    // Truncated weights never sum past one
    a_weight_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_covered |-> ({2'b00, o_weight_a} + {2'b00, o_weight_b}
            + {2'b00, o_weight_c}) <= 19'd65536)
        else $error("weights sum above one");

    // Output register is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");
endmodule

bind triangle_edge_function_rasterizer_top terast_checker u_checker (.*);

// File: bench/terast_checker.sv
// Checker for the rasterizer: watches the channels, predicts fragments and compares them.
module terast_scoreboard (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    input  logic                                   i_cfg_ready,
    input  logic [terast_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [terast_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic                                   i_kind,
    input  logic [terast_pkg::COORD_W-1:0]         i_x0,
    input  logic [terast_pkg::COORD_W-1:0]         i_y0,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_z0,
    input  logic [terast_pkg::COORD_W-1:0]         i_x1,
    input  logic [terast_pkg::COORD_W-1:0]         i_y1,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_z1,
    input  logic [terast_pkg::COORD_W-1:0]         i_x2,
    input  logic [terast_pkg::COORD_W-1:0]         i_y2,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_z2,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic [terast_pkg::COORD_W-1:0]         i_pixel_x,
    input  logic [terast_pkg::COORD_W-1:0]         i_pixel_y,
    input  logic                                   i_covered,
    input  logic [terast_pkg::WEIGHT_W-1:0]        i_weight_a,
    input  logic [terast_pkg::WEIGHT_W-1:0]        i_weight_b,
    input  logic [terast_pkg::WEIGHT_W-1:0]        i_weight_c,
    input  logic signed [terast_pkg::DEPTH_W-1:0]  i_frag_depth,
    input  logic                                   i_last,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    typedef struct packed {
        logic [terast_pkg::COORD_W-1:0]        x;
        logic [terast_pkg::COORD_W-1:0]        y;
        logic                                  cov;
        logic [terast_pkg::WEIGHT_W-1:0]       wa;
        logic [terast_pkg::WEIGHT_W-1:0]       wb;
        logic [terast_pkg::WEIGHT_W-1:0]       wc;
        logic signed [terast_pkg::DEPTH_W-1:0] dep;
        logic                                  last;
    } t_frag;

    t_frag frag_q[$];

    // Shadow of the block state and registers
    logic [terast_pkg::MODE_W-1:0]   mode_r;
    logic [terast_pkg::WEIGHT_W-1:0] band_r;
    longint vx[3], vy[3], vz[3];
    longint det, bminx, bminy, bmaxx, bmaxy, sx, sy;
    int     pidx;
    bit     done;

    assign o_pending = frag_q.size();

    function automatic longint edge_val(longint ax, longint ay, longint bx, longint by,
                                        longint px, longint py);
        return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    endfunction

    function automatic longint absl(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit unit_range(longint e, longint d);
        if (d > 0) return e >= 0 && e <= d;
        return e <= 0 && e >= d;
    endfunction

    // Load a triangle: box, determinant, restart the scan
    task automatic load_triangle();
        longint cx[3], cy[3];
        cx[0] = i_x0; cy[0] = i_y0; vz[0] = i_z0;
        cx[1] = i_x1; cy[1] = i_y1; vz[1] = i_z1;
        cx[2] = i_x2; cy[2] = i_y2; vz[2] = i_z2;
        for (int i = 0; i < 3; i++) begin
            vx[i] = cx[i] > terast_pkg::SCREEN_WIDTH_DEF - 1 ?
                    terast_pkg::SCREEN_WIDTH_DEF - 1 : cx[i];
            vy[i] = cy[i] > terast_pkg::SCREEN_HEIGHT_DEF - 1 ?
                    terast_pkg::SCREEN_HEIGHT_DEF - 1 : cy[i];
        end
        bminx = vx[0]; bmaxx = vx[0]; bminy = vy[0]; bmaxy = vy[0];
        for (int i = 1; i < 3; i++) begin
            if (vx[i] < bminx) bminx = vx[i];
            if (vx[i] > bmaxx) bmaxx = vx[i];
            if (vy[i] < bminy) bminy = vy[i];
            if (vy[i] > bmaxy) bmaxy = vy[i];
        end
        det = edge_val(vx[0], vy[0], vx[1], vy[1], vx[2], vy[2]);
        if (det == 0) det = 1;
        sx = bminx; sy = bminy;
        pidx = 0;
        done = 0;
    endtask

    // One step: scan a pixel or emit a vertex
    task automatic step_fragment();
        t_frag  f;
        longint ea, eb, ec, lim, num, dep;
        int     k;
        bit     cov;
        f = '0;
        if (mode_r == terast_pkg::MODE_POINT) begin
            k = pidx > 2 ? 2 : pidx;
            f.x = 10'(vx[k]); f.y = 10'(vy[k]); f.cov = 1;
            f.wa = (k == 0) ? terast_pkg::WEIGHT_ONE : '0;
            f.wb = (k == 1) ? terast_pkg::WEIGHT_ONE : '0;
            f.wc = (k == 2) ? terast_pkg::WEIGHT_ONE : '0;
            f.dep = 32'(vz[k]);
            f.last = (k == 2);
            if (k == 2) done = 1;
            else pidx = k + 1;
        end else if (bminx >= bmaxx || bminy >= bmaxy) begin
            f.x = 10'(bminx); f.y = 10'(bminy); f.last = 1;
            done = 1;
        end else begin
            ea = edge_val(vx[1], vy[1], vx[2], vy[2], sx, sy);
            eb = edge_val(vx[2], vy[2], vx[0], vy[0], sx, sy);
            ec = edge_val(vx[0], vy[0], vx[1], vy[1], sx, sy);
            cov = unit_range(ea, det) && unit_range(eb, det) && unit_range(ec, det);
            if (cov && mode_r == terast_pkg::MODE_LINE) begin
                lim = longint'(band_r) * absl(det);
                cov = absl(ea) * 65536 < lim || absl(eb) * 65536 < lim ||
                      absl(ec) * 65536 < lim;
            end
            f.x = 10'(sx); f.y = 10'(sy);
            sy++;
            if (sy >= bmaxy) begin
                sy = bminy;
                sx++;
                if (sx >= bmaxx) begin
                    f.last = 1;
                    done = 1;
                end
            end
            if (cov) begin
                num = ea * vz[0] + eb * vz[1] + ec * vz[2];
                dep = num / det;
                if (dep > 64'sd2147483647) dep = 64'sd2147483647;
                if (dep < -64'sd2147483647) dep = -64'sd2147483647;
                f.cov = 1;
                f.wa = 17'((ea * 65536) / det);
                f.wb = 17'((eb * 65536) / det);
                f.wc = 17'((ec * 65536) / det);
                f.dep = 32'(dep);
            end
        end
        frag_q.insert(frag_q.size(), f);
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    // Track transactions on all three channels
    always @(posedge i_clk) begin
        t_frag e;
        if (!i_rst_n) begin
            mode_r = terast_pkg::MODE_FILL; band_r = terast_pkg::BAND_RESET;
            for (int i = 0; i < 3; i++) begin
                vx[i] = 0; vy[i] = 0; vz[i] = 0;
            end
            det = 1; bminx = 0; bminy = 0; bmaxx = 0; bmaxy = 0;
            sx = 0; sy = 0; pidx = 0; done = 1;
            frag_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == terast_pkg::CFG_RASTER_MODE)
                    mode_r = i_cfg_data[terast_pkg::MODE_W-1:0];
                else if (i_cfg_index == terast_pkg::CFG_EDGE_BAND)
                    band_r = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (i_kind == terast_pkg::KIND_LOAD) load_triangle();
                else if (!done) step_fragment();
            end
            if (i_out_valid && i_out_ready) begin
                if (frag_q.size() == 0) begin
                    $display("%0t unexpected fragment at (%0d,%0d)", $time,
                             i_pixel_x, i_pixel_y);
                    o_fail_count++;
                end else begin
                    e = frag_q.pop_front();
                    check_field("pixel_x", e.x, i_pixel_x);
                    check_field("pixel_y", e.y, i_pixel_y);
                    check_field("covered", e.cov, i_covered);
                    check_field("weight_a", e.wa, i_weight_a);
                    check_field("weight_b", e.wb, i_weight_b);
                    check_field("weight_c", e.wc, i_weight_c);
                    check_field("frag_depth", e.dep, i_frag_depth);
                    check_field("last", e.last, i_last);
                end
            end
        end
    end

endmodule

// File: bench/tb_triangle_edge_function_rasterizer_top.sv
// Testbench top for the rasterizer: stimulus, idling phases and the verdict.
module tb_triangle_edge_function_rasterizer_top;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 150;
    localparam int ITEM_TARGET = 1150;

    // Index that names no register
    localparam logic [terast_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                                  i_clk = 0;
    logic                                  i_rst_n = 0;
    logic                                  i_cfg_valid = 0;
    logic                                  o_cfg_ready;
    logic [terast_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [terast_pkg::CFG_DATA_W-1:0]     i_cfg_data = '0;
    logic                                  i_in_valid = 0;
    logic                                  o_in_ready;
    logic                                  i_kind = 0;
    logic [terast_pkg::COORD_W-1:0]        i_x0 = '0, i_y0 = '0, i_x1 = '0, i_y1 = '0;
    logic [terast_pkg::COORD_W-1:0]        i_x2 = '0, i_y2 = '0;
    logic signed [terast_pkg::DEPTH_W-1:0] i_z0 = '0, i_z1 = '0, i_z2 = '0;
    logic                                  o_out_valid;
    logic                                  i_out_ready = 0;
    logic [terast_pkg::COORD_W-1:0]        o_pixel_x, o_pixel_y;
    logic                                  o_covered, o_last;
    logic [terast_pkg::WEIGHT_W-1:0]       o_weight_a, o_weight_b, o_weight_c;
    logic signed [terast_pkg::DEPTH_W-1:0] o_frag_depth;

    int        fail_count, pending;
    int        idle_phase = 0;    // 0 none, 1 sender, 2 receiver, 3 both
    bit        hold_req = 0;
    int        hold_cnt = 0;
    logic [1:0] cur_mode = terast_pkg::MODE_FILL;
    int        item_count = 0;

    always #6 i_clk = ~i_clk;

    triangle_edge_function_rasterizer_top dut (.*);

    terast_scoreboard u_scoreboard (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_in_valid, .i_in_ready(o_in_ready), .i_kind,
        .i_x0, .i_y0, .i_z0, .i_x1, .i_y1, .i_z1, .i_x2, .i_y2, .i_z2,
        .i_out_valid(o_out_valid), .i_out_ready, .i_pixel_x(o_pixel_x),
        .i_pixel_y(o_pixel_y), .i_covered(o_covered), .i_weight_a(o_weight_a),
        .i_weight_b(o_weight_b), .i_weight_c(o_weight_c),
        .i_frag_depth(o_frag_depth), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_req && hold_cnt == 0) begin
            hold_cnt <= 400;
            i_out_ready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= (hold_cnt == 1);
        end else if (idle_phase == 2) begin
            i_out_ready <= ($urandom_range(0, 99) >= 57);
        end else if (idle_phase == 3) begin
            i_out_ready <= ($urandom_range(0, 99) >= 31);
        end else begin
            i_out_ready <= 1;
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // Offer one item and hold it until the transaction completes
    task automatic send_item(logic kind, logic [9:0] ax, logic [9:0] ay, logic [31:0] az,
                             logic [9:0] bx, logic [9:0] by, logic [31:0] bz,
                             logic [9:0] cx, logic [9:0] cy, logic [31:0] cz);
        int pct;
        pct = (idle_phase == 1) ? 57 : (idle_phase == 3) ? 31 : 0;
        if ($urandom_range(0, 99) < pct) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_kind <= kind;
        i_x0 <= ax; i_y0 <= ay; i_z0 <= az;
        i_x1 <= bx; i_y1 <= by; i_z1 <= bz;
        i_x2 <= cx; i_y2 <= cy; i_z2 <= cz;
        do @(posedge i_clk); while (!o_in_ready);
        item_count++;
    endtask

    task automatic step_item();
        send_item(terast_pkg::KIND_STEP, 10'($urandom), 10'($urandom), $urandom,
                  10'($urandom), 10'($urandom), $urandom,
                  10'($urandom), 10'($urandom), $urandom);
    endtask

    // Let the last accepted item be counted, then wait until all results are out
    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Register write, only once the block has gone idle
    task automatic set_reg(logic [terast_pkg::CFG_IDX_W-1:0] idx,
                           logic [terast_pkg::CFG_DATA_W-1:0] data);
        drain();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        if (idx == terast_pkg::CFG_RASTER_MODE) cur_mode = data[1:0];
    endtask

    // Load a triangle, then step through its box with a few extra steps
    task automatic triangle_run(logic [9:0] ax, logic [9:0] ay, logic [9:0] bx,
                                logic [9:0] by, logic [9:0] cx, logic [9:0] cy,
                                logic [31:0] az, logic [31:0] bz, logic [31:0] cz,
                                int extra);
        int w, h, n;
        w = (ax > bx ? ax : bx); w = (w > cx ? w : cx);
        w = w - (ax < bx ? (ax < cx ? ax : cx) : (bx < cx ? bx : cx));
        h = (ay > by ? ay : by); h = (h > cy ? h : cy);
        h = h - (ay < by ? (ay < cy ? ay : cy) : (by < cy ? by : cy));
        send_item(terast_pkg::KIND_LOAD, ax, ay, az, bx, by, bz, cx, cy, cz);
        n = (cur_mode == terast_pkg::MODE_POINT) ? 3 : ((w == 0 || h == 0) ? 1 : w * h);
        repeat (n + extra) step_item();
    endtask

    function automatic logic [9:0] near(int base);
        int v;
        v = base + $urandom_range(0, 6);
        return v > 1023 ? 10'd1023 : v[9:0];
    endfunction

    initial begin
        int bx, by, seg;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: fill, extremes, degenerate, orientation, modes
        triangle_run(0, 0, 4, 0, 0, 4, 32'h7fffffff, 32'h80000001, 0, 1);
        triangle_run(1023, 1023, 1023, 1023, 1023, 1023, 32'h80000000, 32'hffffffff,
                     32'h7fffffff, 1);
        triangle_run(0, 0, 2, 2, 4, 4, 1000, -1000, 5, 0);
        triangle_run(0, 0, 0, 3, 3, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        set_reg(terast_pkg::CFG_RASTER_MODE, 17'(terast_pkg::MODE_POINT));
        triangle_run(1023, 0, 0, 1023, 5, 7, 32'h80000000, 32'h7fffffff, 1, 1);
        set_reg(terast_pkg::CFG_RASTER_MODE, 17'(terast_pkg::MODE_LINE));
        set_reg(terast_pkg::CFG_EDGE_BAND, 17'd65536);
        triangle_run(10, 10, 14, 10, 10, 14, 0, 1, 2, 0);
        set_reg(terast_pkg::CFG_EDGE_BAND, 17'd0);
        triangle_run(10, 10, 14, 10, 10, 14, 0, 1, 2, 0);
        set_reg(terast_pkg::CFG_RASTER_MODE, 17'h1ffff);
        set_reg(CFG_SPARE, 17'h1ffff);
        triangle_run(3, 3, 0, 5, 6, 6, -5, 7, 9, 0);

        // Random segments with changing settings and idling
        seg = 0;
        while (item_count < ITEM_TARGET) begin
            set_reg(terast_pkg::CFG_RASTER_MODE, 17'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: set_reg(terast_pkg::CFG_EDGE_BAND, 17'd0);
                1: set_reg(terast_pkg::CFG_EDGE_BAND, 17'd65536);
                2: set_reg(terast_pkg::CFG_EDGE_BAND, terast_pkg::BAND_RESET);
                default: set_reg(terast_pkg::CFG_EDGE_BAND, 17'($urandom_range(0, 65536)));
            endcase
            idle_phase = seg % 4;
            if (seg % 4 == 2) hold_req = 1;
            repeat (20) begin
                if ($urandom_range(0, 99) < 85) begin
                    bx = $urandom_range(0, 1023);
                    by = $urandom_range(0, 1023);
                    triangle_run(near(bx), near(by), near(bx), near(by), near(bx),
                                 near(by), $urandom, $urandom, $urandom,
                                 $urandom_range(0, 2));
                end else begin
                    send_item(1'($urandom), 10'($urandom), 10'($urandom), $urandom,
                              10'($urandom), 10'($urandom), $urandom,
                              10'($urandom), 10'($urandom), $urandom);
                end
                hold_req = 0;
            end
            seg++;
        end

        drain();
        if (fail_count == 0 && pending == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
